### rtl/core/ppmfg_pkg.sv
// shared types, constants and helpers for the ppm frame generator
// no dependencies; used by every module of the block
package ppmfg_pkg;

  localparam int MAX_CHANNELS_DEF = 16;

  localparam int FUNC_W     = 1;
  localparam int CHAN_W     = 5;
  localparam int VAL_W      = 12;
  localparam int FRAME_W    = 16;
  localparam int SUM_W      = 17;
  localparam int TICK_W     = 17;
  localparam int CNT_W      = 6;   // holds a channel count up to 32
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;  // chan_index and chan_value padded to bytes
  localparam int OUT_DATA_W = 8;   // ppm_out and write_ok padded to a byte

  localparam logic [VAL_W-1:0]   CHAN_DEFAULT   = 12'd1500;
  localparam logic [TICK_W-1:0]  TICKS_AT_RESET = 17'd100;
  localparam logic [SUM_W-1:0]   SUM_MAX        = {SUM_W{1'b1}};

  localparam logic               ENABLE_RST       = 1'b0;
  localparam logic [CHAN_W-1:0]  NUM_CHANNELS_RST = 5'd8;
  localparam logic [VAL_W-1:0]   PULSE_LEN_RST    = 12'd300;
  localparam logic [FRAME_W-1:0] FRAME_LEN_RST    = 16'd22500;
  localparam logic               ACTIVE_LEVEL_RST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_NUM_CHANNELS = 3'd1,
    REG_PULSE_LEN    = 3'd2,
    REG_FRAME_LEN    = 3'd3,
    REG_ACTIVE_LEVEL = 3'd4
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [CHAN_W-1:0]  chan_index;
    logic [VAL_W-1:0]   chan_value;
  } item_t;

  typedef struct packed {
    logic ppm_out;
    logic write_ok;
  } result_t;

  typedef struct packed {
    logic               enable;
    logic [CHAN_W-1:0]  num_channels;
    logic [VAL_W-1:0]   pulse_len_us;
    logic [FRAME_W-1:0] frame_len_us;
    logic               active_level;
  } cfg_t;

  // saturating add for the running frame sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

### rtl/core/ppmfg_cfg_regs.sv
// configuration register file of the ppm frame generator
// depends on ppmfg_pkg
module ppmfg_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppmfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmfg_pkg::CFG_DATA_W-1:0] cfg_data,
  output ppmfg_pkg::cfg_t                  cfg
);

  ppmfg_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (ppmfg_pkg::cfg_reg_t'(cfg_index))
        ppmfg_pkg::REG_ENABLE:       cfg_nxt.enable       = cfg_data[0];
        ppmfg_pkg::REG_NUM_CHANNELS: cfg_nxt.num_channels = cfg_data[ppmfg_pkg::CHAN_W-1:0];
        ppmfg_pkg::REG_PULSE_LEN:    cfg_nxt.pulse_len_us = cfg_data[ppmfg_pkg::VAL_W-1:0];
        ppmfg_pkg::REG_FRAME_LEN:    cfg_nxt.frame_len_us = cfg_data[ppmfg_pkg::FRAME_W-1:0];
        ppmfg_pkg::REG_ACTIVE_LEVEL: cfg_nxt.active_level = cfg_data[0];
        default:                     cfg_nxt = cfg_r;  // unused indexes are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= ppmfg_pkg::ENABLE_RST;
      cfg_r.num_channels <= ppmfg_pkg::NUM_CHANNELS_RST;
      cfg_r.pulse_len_us <= ppmfg_pkg::PULSE_LEN_RST;
      cfg_r.frame_len_us <= ppmfg_pkg::FRAME_LEN_RST;
      cfg_r.active_level <= ppmfg_pkg::ACTIVE_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/core/ppmfg_in_reg.sv
// input register stage: captures one item per transfer
// depends on ppmfg_pkg
module ppmfg_in_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ppmfg_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                            in_tuser,
  input  logic                            take,
  output logic                            item_valid,
  output ppmfg_pkg::item_t                item
);

  logic             valid_r, valid_nxt;
  ppmfg_pkg::item_t item_r;
  logic             in_fire;

  assign in_tready  = !valid_r || take;
  assign in_fire    = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.func       <= ppmfg_pkg::func_t'(in_tuser);
      item_r.chan_index <= in_tdata[ppmfg_pkg::CHAN_W-1:0];
      item_r.chan_value <= in_tdata[ppmfg_pkg::CHAN_W +: ppmfg_pkg::VAL_W];
    end
  end

endmodule

### rtl/core/ppmfg_engine.sv
// frame timing state and channel store; applies one item when step is high
// depends on ppmfg_pkg
module ppmfg_engine #(
  parameter int MAX_CHANNELS = ppmfg_pkg::MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ppmfg_pkg::item_t   item,
  input  ppmfg_pkg::cfg_t    cfg,
  output ppmfg_pkg::result_t result
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [ppmfg_pkg::CNT_W-1:0] MAX_CNT = ppmfg_pkg::CNT_W'(MAX_CHANNELS);

  logic [ppmfg_pkg::VAL_W-1:0]  store_r [MAX_CHANNELS];

  logic                         gap_r, gap_nxt;
  logic [ppmfg_pkg::CHAN_W-1:0] cur_r, cur_nxt;
  logic [ppmfg_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [ppmfg_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic                         pin_r, pin_nxt;

  logic [ppmfg_pkg::CNT_W-1:0]  chan_count;
  logic                         write_hit;
  logic                         tick;
  logic                         frame_end;
  logic [ppmfg_pkg::VAL_W-1:0]  rd_val;
  logic [ppmfg_pkg::VAL_W-1:0]  gap_diff;
  logic [ppmfg_pkg::SUM_W-1:0]  used;
  logic [ppmfg_pkg::SUM_W-1:0]  fill_diff;

  assign chan_count = ({1'b0, cfg.num_channels} > MAX_CNT) ? MAX_CNT
                                                           : {1'b0, cfg.num_channels};
  assign write_hit  = (item.func == ppmfg_pkg::FUNC_WRITE)
                   && ({1'b0, item.chan_index} < chan_count);
  assign tick       = (item.func == ppmfg_pkg::FUNC_TICK) && cfg.enable;
  assign frame_end  = {1'b0, cur_r} >= chan_count;
  assign rd_val     = store_r[cur_r[IW-1:0]];
  assign gap_diff   = rd_val - cfg.pulse_len_us;
  assign used       = ppmfg_pkg::sat_add(sum_r, ppmfg_pkg::SUM_W'(cfg.pulse_len_us));
  assign fill_diff  = ppmfg_pkg::SUM_W'(cfg.frame_len_us) - used;

  always_comb begin
    gap_nxt   = gap_r;
    cur_nxt   = cur_r;
    sum_nxt   = sum_r;
    ticks_nxt = ticks_r;
    pin_nxt   = pin_r;
    if (tick) begin
      if (ticks_r <= ppmfg_pkg::TICK_W'(1)) begin
        if (gap_r) begin
          // gap over: start a marker pulse
          pin_nxt   = cfg.active_level;
          ticks_nxt = {4'b0, cfg.pulse_len_us, 1'b0};
          gap_nxt   = 1'b0;
        end else begin
          pin_nxt = ~cfg.active_level;
          gap_nxt = 1'b1;
          if (frame_end) begin
            // fill gap up to the frame length
            cur_nxt   = '0;
            ticks_nxt = (ppmfg_pkg::SUM_W'(cfg.frame_len_us) > used)
                      ? {fill_diff[ppmfg_pkg::FRAME_W-1:0], 1'b0} : '0;
            sum_nxt   = '0;
          end else begin
            ticks_nxt = (rd_val > cfg.pulse_len_us) ? {4'b0, gap_diff, 1'b0} : '0;
            sum_nxt   = ppmfg_pkg::sat_add(sum_r, ppmfg_pkg::SUM_W'(rd_val));
            cur_nxt   = cur_r + 1'b1;
          end
        end
      end else begin
        ticks_nxt = ticks_r - 1'b1;
      end
    end
  end

  assign result.ppm_out  = pin_nxt;
  assign result.write_ok = write_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r   <= 1'b0;
      cur_r   <= '0;
      sum_r   <= '0;
      ticks_r <= ppmfg_pkg::TICKS_AT_RESET;
      pin_r   <= ~ppmfg_pkg::ACTIVE_LEVEL_RST;
    end else if (step) begin
      gap_r   <= gap_nxt;
      cur_r   <= cur_nxt;
      sum_r   <= sum_nxt;
      ticks_r <= ticks_nxt;
      pin_r   <= pin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        store_r[i] <= ppmfg_pkg::CHAN_DEFAULT;
      end
    end else if (step && write_hit) begin
      store_r[item.chan_index[IW-1:0]] <= item.chan_value;
    end
  end

endmodule

### rtl/core/ppmfg_out_reg.sv
// result register on the master side, holds a result until its transfer
// depends on ppmfg_pkg
module ppmfg_out_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  ppmfg_pkg::result_t               result,
  output logic                             can_take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ppmfg_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic               valid_r, valid_nxt;
  ppmfg_pkg::result_t result_r;

  assign can_take   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b0, result_r.write_ok, result_r.ppm_out};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

### rtl/core/ppm_frame_generator.sv
// top level of the ppm frame generator: input stage, engine, result stage, config
// depends on ppmfg_pkg, ppmfg_cfg_regs, ppmfg_in_reg, ppmfg_engine, ppmfg_out_reg
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in_     | slave     | in_tvalid/in_tready | tuser: func; tdata: index, value
//   out_    | master    | out_tvalid/tready   | tdata: ppm_out, write_ok
//   cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one item per cycle while out_tready is high; an item reaches out_ through
// the input register, then the engine's next-state logic feeding the result register
// the engine updates its state in the same cycle an item moves into the result register
// reset is synchronous, rst_n low; the channel store comes out of reset at 1500 us
// out_tready low stalls the result register and, through it, the input register
// cfg_ready is always high; the user must write registers with the block idle; unenforced
module ppm_frame_generator #(
  parameter int MAX_CHANNELS = ppmfg_pkg::MAX_CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ppmfg_pkg::IN_DATA_W-1:0]  in_tdata,   // [4:0] chan_index, [16:5] chan_value
  input  logic                             in_tuser,   // [0] func
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ppmfg_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] ppm_out, [1] write_ok
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppmfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppmfg_pkg::CFG_DATA_W-1:0] cfg_data
);

  ppmfg_pkg::cfg_t    cfg;
  ppmfg_pkg::item_t   item;
  ppmfg_pkg::result_t result;
  logic               item_valid;
  logic               can_take;
  logic               advance;

  // an item in the input register moves on whenever the result register frees up
  assign advance = item_valid && can_take;

  ppmfg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppmfg_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // state advances only when the item's result is captured
  ppmfg_engine #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  ppmfg_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/ppmfg_checker.sv
// port-level checks for the ppm frame generator, bound to the top level
// depends on ppmfg_pkg and ppm_frame_generator
module ppmfg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ppmfg_pkg::OUT_DATA_W-1:0] out_tdata
);

  // the only reason to refuse input is a stalled result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input refused without a stalled result");

  // padding bits of a result stay zero
  a_out_padding: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ppmfg_pkg::OUT_DATA_W-1:2] == '0))
    else $error("result padding not zero");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind ppm_frame_generator ppmfg_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
